// ===== hdl/height_tile_stats_and_class_mode_assert.svh =====
// assertion macros for the height tile statistics block
// used by the top level only, no other dependencies
`ifndef HEIGHT_TILE_STATS_AND_CLASS_MODE_ASSERT_SVH
`define HEIGHT_TILE_STATS_AND_CLASS_MODE_ASSERT_SVH

// same-cycle implication
`define HTSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HTSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/htsc_pkg.sv =====
// shared types and constants for the height tile statistics block
// no dependencies
package htsc_pkg;

   localparam int HEIGHT_W    = 24;
   localparam int BIOME_W     = 8;
   localparam int TILE_W      = 32;
   localparam int POS_SHIFT   = 4;
   localparam int POS_W       = TILE_W + POS_SHIFT;
   localparam int LEVEL_W     = 3;
   localparam int COUNT_OUT_W = 9;
   localparam int EPOCH_W     = 8;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic [BIOME_W-1:0]         biome;
      logic                       biome_present;
      logic signed [TILE_W-1:0]   tile_x;
      logic signed [TILE_W-1:0]   tile_z;
      logic [LEVEL_W-1:0]         detail_level;
      logic                       last;
   } req_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0]    pos_x;
      logic signed [POS_W-1:0]    pos_z;
      logic [LEVEL_W-1:0]         level_out;
      logic signed [HEIGHT_W-1:0] mean_height;
      logic signed [HEIGHT_W-1:0] min_height;
      logic signed [HEIGHT_W-1:0] max_height;
      logic [HEIGHT_W-1:0]        height_span;
      logic [BIOME_W-1:0]         dominant_biome;
      logic                       dominant_valid;
      logic [COUNT_OUT_W-1:0]     sample_count;
      logic                       overflow;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_DIV,
      ST_LOAD
   } htsc_state_type;

endpackage

// ===== hdl/htsc_div.sv =====
// bit-serial signed divider for the tile mean, truncates toward zero
// one quotient bit per cycle, no package dependencies
module htsc_div #(
   parameter int SUM_W = 33,
   parameter int CNT_W = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0]        divisor,
   output logic                    done,
   output logic signed [SUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;
   logic [CNT_W-1:0]  rem_in;
   logic [SUM_W-1:0]  mag;

   assign trial  = {rem_ff, quo_ff[SUM_W-1]};
   assign diff   = trial - {1'b0, divisor};
   assign fits   = trial >= {1'b0, divisor};
   assign rem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
   assign mag    = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= '0;
         rem_ff  <= '0;
         quo_ff  <= mag;
         neg_ff  <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         step_ff <= step_ff + STEP_W'(1);
         rem_ff  <= rem_in;
         quo_ff  <= {quo_ff[SUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -signed'(quo_ff) : signed'(quo_ff);

endmodule

// ===== hdl/height_tile_stats_and_class_mode.sv =====
// top level of the height tile statistics block: min, max, mean and class mode
// depends on htsc_pkg, htsc_div and height_tile_stats_and_class_mode_assert.svh
//
// Samples of a tile are taken one per clock while req_stall is low. The class
// histogram lives in a CLASS_COUNT-entry memory updated by read-modify-write,
// a registered read followed by write-back, with forwarding, each entry tagged
// with a tile number so it needs no clearing between tiles but when that number
// wraps. The closing sample is followed by a drain state, then the serial mean
// divider (one quotient bit per cycle, then a done flag), then a load state that
// writes the result register; input is stalled through all of these, and
// longer while an earlier result still waits. After reset, and again after every
// 256th tile when the tile number wraps, a pass over all CLASS_COUNT entries zeroes
// the histogram memory before samples are taken. A finished result waits in
// its own register while the next tile streams in.
`include "height_tile_stats_and_class_mode_assert.svh"

module height_tile_stats_and_class_mode #(
   parameter int MAX_SAMPLES      = 256,
   parameter int CLASS_COUNT      = 256,
   parameter int HEIGHT_FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  htsc_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output htsc_pkg::rsp_item_type rsp_item
);

   import htsc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = HEIGHT_W + CNT_W;
   localparam int CLS_AW = $clog2(CLASS_COUNT);
   localparam int CMP_W  = ((CLS_AW > BIOME_W) ? CLS_AW : BIOME_W) + 1;
   localparam int ENT_W  = EPOCH_W + CNT_W;
   localparam logic signed [HEIGHT_W:0] SPAN_ONE = (HEIGHT_W + 1)'(1 << HEIGHT_FRAC_BITS);

   // histogram memory: tile tag and count per class
   logic [ENT_W-1:0] hist_mem [CLASS_COUNT];

   htsc_state_type state_ff, state_in;

   logic signed [HEIGHT_W-1:0] min_ff, max_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]           seen_ff;
   logic                       ovf_ff;
   logic [CLS_AW-1:0]          best_cls_ff;
   logic [CNT_W-1:0]           best_cnt_ff;
   logic [EPOCH_W-1:0]         epoch_ff;
   logic [CLS_AW-1:0]          clr_addr_ff;

   logic                       s1_valid_ff;
   logic [CLS_AW-1:0]          s1_addr_ff;
   logic [ENT_W-1:0]           rd_ent_ff;
   logic                       fwd_ff;
   logic [CNT_W-1:0]           fwd_cnt_ff;

   logic signed [TILE_W-1:0]   tx_ff, tz_ff;
   logic [LEVEL_W-1:0]         lvl_ff;

   logic                       rsp_valid_ff;
   rsp_item_type               rsp_item_ff;

   logic                       req_acc;
   logic                       room;
   logic                       take;
   logic [CMP_W-1:0]           biome_wide;
   logic                       in_range;
   logic                       hist_go;
   logic [CLS_AW-1:0]          hist_addr;
   logic [CNT_W-1:0]           s1_old;
   logic [CNT_W-1:0]           s1_new;
   logic                       s1_better;
   logic                       div_start;
   logic                       div_done;
   logic signed [SUM_W-1:0]    div_quo;
   logic                       load_go;
   logic signed [HEIGHT_W:0]   span_raw;
   logic signed [HEIGHT_W:0]   span_fl;

   assign req_stall  = (state_ff != ST_RUN);
   assign req_acc    = req_valid && (state_ff == ST_RUN);
   assign room       = seen_ff < CNT_W'(MAX_SAMPLES);
   assign take       = req_acc && room;
   assign biome_wide = CMP_W'(req_item.biome);
   assign in_range   = biome_wide < CMP_W'(CLASS_COUNT);
   assign hist_go    = take && req_item.biome_present && in_range;
   assign hist_addr  = biome_wide[CLS_AW-1:0];

   // count seen by the write-back stage: forwarded, current tile, or stale
   always_comb begin
      if (fwd_ff) begin
         s1_old = fwd_cnt_ff;
      end else if (rd_ent_ff[ENT_W-1:CNT_W] == epoch_ff) begin
         s1_old = rd_ent_ff[CNT_W-1:0];
      end else begin
         s1_old = '0;
      end
   end

   assign s1_new    = s1_old + CNT_W'(1);
   assign s1_better = s1_valid_ff && (s1_new > best_cnt_ff);

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      load_go   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == CLS_AW'(CLASS_COUNT - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (req_valid && req_item.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_go  = 1'b1;
               state_in = (epoch_ff == '1) ? ST_CLEAR : ST_RUN;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         epoch_ff    <= '0;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= hist_go;
         fwd_ff      <= s1_valid_ff && (s1_addr_ff == hist_addr);
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + CLS_AW'(1);
         end else begin
            clr_addr_ff <= '0;
         end
         if (load_go) begin
            epoch_ff <= epoch_ff + EPOCH_W'(1);
         end
      end
   end

   // histogram read-modify-write
   always_ff @(posedge clock) begin
      if (hist_go) begin
         rd_ent_ff <= hist_mem[hist_addr];
      end
      if (state_ff == ST_CLEAR) begin
         hist_mem[clr_addr_ff] <= {epoch_ff, CNT_W'(0)};
      end else if (s1_valid_ff) begin
         hist_mem[s1_addr_ff] <= {epoch_ff, s1_new};
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= hist_addr;
      fwd_cnt_ff <= s1_new;
   end

   // running statistics
   always_ff @(posedge clock) begin
      if (reset || load_go) begin
         min_ff      <= {1'b0, {(HEIGHT_W - 1){1'b1}}};
         max_ff      <= {1'b1, {(HEIGHT_W - 1){1'b0}}};
         sum_ff      <= '0;
         seen_ff     <= '0;
         ovf_ff      <= 1'b0;
         best_cls_ff <= '0;
         best_cnt_ff <= '0;
      end else begin
         if (take) begin
            if (req_item.height < min_ff) begin
               min_ff <= req_item.height;
            end
            if (req_item.height > max_ff) begin
               max_ff <= req_item.height;
            end
            sum_ff  <= sum_ff + SUM_W'(req_item.height);
            seen_ff <= seen_ff + CNT_W'(1);
         end else if (req_acc) begin
            ovf_ff <= 1'b1;
         end
         if (s1_better) begin
            best_cls_ff <= s1_addr_ff;
            best_cnt_ff <= s1_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_item.last) begin
         tx_ff  <= req_item.tile_x;
         tz_ff  <= req_item.tile_z;
         lvl_ff <= req_item.detail_level;
      end
   end

   htsc_div #(
      .SUM_W(SUM_W),
      .CNT_W(CNT_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(sum_ff),
      .divisor (seen_ff),
      .done    (div_done),
      .quotient(div_quo)
   );

   assign span_raw = (HEIGHT_W + 1)'(max_ff) - (HEIGHT_W + 1)'(min_ff);
   assign span_fl  = (span_raw < SPAN_ONE) ? SPAN_ONE : span_raw;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_go) begin
         rsp_item_ff.pos_x          <= {tx_ff, POS_SHIFT'(0)};
         rsp_item_ff.pos_z          <= {tz_ff, POS_SHIFT'(0)};
         rsp_item_ff.level_out      <= lvl_ff;
         rsp_item_ff.mean_height    <= HEIGHT_W'(div_quo);
         rsp_item_ff.min_height     <= min_ff;
         rsp_item_ff.max_height     <= max_ff;
         rsp_item_ff.height_span    <= span_fl[HEIGHT_W-1:0];
         rsp_item_ff.dominant_biome <= BIOME_W'(best_cls_ff);
         rsp_item_ff.dominant_valid <= (best_cnt_ff != '0);
         rsp_item_ff.sample_count   <= COUNT_OUT_W'(seen_ff);
         rsp_item_ff.overflow       <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `HTSC_ASSERT_IMP(a_best_le_seen, clock, reset, 1'b1,
      best_cnt_ff <= seen_ff, "class count above sample count")
   `HTSC_ASSERT_IMP(a_hist_stage, clock, reset, s1_valid_ff,
      state_ff == ST_RUN || state_ff == ST_DRAIN, "histogram write outside tile")
   `HTSC_ASSERT_IMP(a_div_done, clock, reset, div_done,
      state_ff == ST_DIV, "divider finished out of turn")
   `HTSC_ASSERT_NEXT(a_load_clears, clock, reset, load_go,
      rsp_valid_ff && seen_ff == '0 && best_cnt_ff == '0, "tile state not cleared on result")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// testbench for height_tile_stats_and_class_mode: sends tiles of height samples, computes each
// tile summary on its own side and compares it field by field with the block's result items
// depends on htsc_pkg and the rtl of height_tile_stats_and_class_mode
module tb;
   import htsc_pkg::*;

   localparam int MAX_SAMPLES = 256;
   localparam int CLASS_COUNT = 256;
   localparam int FRAC_BITS = 8;
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_TOP = {1'b0, {(HEIGHT_W-1){1'b1}}};
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_BOTTOM = {1'b1, {(HEIGHT_W-1){1'b0}}};
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   int src_idle_pct = 0;
   int sink_stall_pct = 0;
   int samples_sent = 0;
   int summaries_checked = 0;
   int overflow_tiles = 0;
   int errors = 0;
   int quiet_cycles = 0;

   // running statistics of the tile being received
   logic signed [HEIGHT_W-1:0] tile_min;
   logic signed [HEIGHT_W-1:0] tile_max;
   longint tile_sum;
   int tile_count;
   int class_hist [CLASS_COUNT];
   logic [BIOME_W-1:0] mode_class;
   int mode_count;
   logic tile_overflow;
   rsp_item_type expected_summaries [$];

   height_tile_stats_and_class_mode #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .CLASS_COUNT(CLASS_COUNT),
      .HEIGHT_FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_tile();
      tile_min = HEIGHT_TOP;
      tile_max = HEIGHT_BOTTOM;
      tile_sum = 0;
      tile_count = 0;
      foreach (class_hist[i]) class_hist[i] = 0;
      mode_class = '0;
      mode_count = 0;
      tile_overflow = 1'b0;
   endfunction

   function automatic void fold_sample(input req_item_type s);
      rsp_item_type summary;
      int span;
      if (tile_count < MAX_SAMPLES) begin
         if (s.height < tile_min) tile_min = s.height;
         if (s.height > tile_max) tile_max = s.height;
         tile_sum += longint'(s.height);
         tile_count++;
         if (s.biome_present && int'(s.biome) < CLASS_COUNT) begin
            class_hist[s.biome]++;
            if (class_hist[s.biome] > mode_count) begin
               mode_count = class_hist[s.biome];
               mode_class = s.biome;
            end
         end
      end else begin
         tile_overflow = 1'b1;
      end
      if (s.last) begin
         span = int'(tile_max) - int'(tile_min);
         if (span < (1 << FRAC_BITS)) span = 1 << FRAC_BITS;
         summary.pos_x = {s.tile_x, {POS_SHIFT{1'b0}}};
         summary.pos_z = {s.tile_z, {POS_SHIFT{1'b0}}};
         summary.level_out = s.detail_level;
         summary.mean_height = HEIGHT_W'(tile_sum / tile_count);
         summary.min_height = tile_min;
         summary.max_height = tile_max;
         summary.height_span = HEIGHT_W'(span);
         summary.dominant_biome = mode_class;
         summary.dominant_valid = (mode_count > 0);
         summary.sample_count = COUNT_OUT_W'(tile_count);
         summary.overflow = tile_overflow;
         if (tile_overflow) overflow_tiles++;
         expected_summaries.push_back(summary);
         clear_tile();
      end
   endfunction

   function automatic void mismatch(input string field, input longint want, input longint got);
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
   endfunction

   function automatic void check_summary(input rsp_item_type got, input rsp_item_type want);
      if (got.pos_x !== want.pos_x) mismatch("pos_x", want.pos_x, got.pos_x);
      if (got.pos_z !== want.pos_z) mismatch("pos_z", want.pos_z, got.pos_z);
      if (got.level_out !== want.level_out) mismatch("level_out", want.level_out, got.level_out);
      if (got.mean_height !== want.mean_height)
         mismatch("mean_height", want.mean_height, got.mean_height);
      if (got.min_height !== want.min_height)
         mismatch("min_height", want.min_height, got.min_height);
      if (got.max_height !== want.max_height)
         mismatch("max_height", want.max_height, got.max_height);
      if (got.height_span !== want.height_span)
         mismatch("height_span", want.height_span, got.height_span);
      if (got.dominant_biome !== want.dominant_biome)
         mismatch("dominant_biome", want.dominant_biome, got.dominant_biome);
      if (got.dominant_valid !== want.dominant_valid)
         mismatch("dominant_valid", want.dominant_valid, got.dominant_valid);
      if (got.sample_count !== want.sample_count)
         mismatch("sample_count", want.sample_count, got.sample_count);
      if (got.overflow !== want.overflow) mismatch("overflow", want.overflow, got.overflow);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_summaries.size() == 0) begin
            $error("tile summary arrived with none expected");
            errors++;
         end else begin
            check_summary(rsp_item, expected_summaries.pop_front());
            summaries_checked++;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_item_type make_sample(input logic signed [HEIGHT_W-1:0] h,
         input logic [BIOME_W-1:0] b, input logic present, input logic is_last);
      req_item_type s;
      s.height = h;
      s.biome = b;
      s.biome_present = present;
      s.tile_x = $urandom;
      s.tile_z = $urandom;
      s.detail_level = LEVEL_W'($urandom_range(7));
      s.last = is_last;
      return s;
   endfunction

   function automatic req_item_type random_sample(input logic is_last);
      logic signed [HEIGHT_W-1:0] h;
      logic [BIOME_W-1:0] b;
      case ($urandom_range(9))
         0: h = HEIGHT_TOP;
         1: h = HEIGHT_BOTTOM;
         2, 3, 4: h = HEIGHT_W'(int'($urandom_range(1024)) - 512);
         default: h = HEIGHT_W'($urandom);
      endcase
      // a few classes only, half the time, so that ties come up
      b = $urandom_range(1) ? BIOME_W'($urandom_range(3)) : BIOME_W'($urandom);
      return make_sample(h, b, $urandom_range(3) != 0, is_last);
   endfunction

   task automatic send_sample(input req_item_type s);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= s;
      do @(posedge clock); while (req_stall);
      fold_sample(s);
      samples_sent++;
   endtask

   task automatic send_tile(input int length);
      for (int i = 1; i <= length; i++) send_sample(random_sample(i == length));
   endtask

   task automatic test_single_sample_tiles();
      req_item_type s;
      s = make_sample(HEIGHT_TOP, 8'hff, 1'b1, 1'b1);
      s.tile_x = 32'h7fff_ffff;
      s.tile_z = 32'h8000_0000;
      s.detail_level = 3'd7;
      send_sample(s);
      s = make_sample(HEIGHT_BOTTOM, 8'h00, 1'b0, 1'b1);
      s.tile_x = '1;
      s.tile_z = '0;
      s.detail_level = 3'd0;
      send_sample(s);
      send_sample(make_sample('0, 8'h80, 1'b1, 1'b1));
   endtask

   task automatic test_full_height_span();
      send_sample(make_sample(HEIGHT_BOTTOM, 8'h01, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_TOP, 8'h02, 1'b1, 1'b1));
   endtask

   task automatic test_mean_truncation();
      send_sample(make_sample(HEIGHT_W'(-3), 8'h10, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_W'(-2), 8'h10, 1'b1, 1'b1));
      send_sample(make_sample(HEIGHT_W'(1), 8'h11, 1'b0, 1'b0));
      send_sample(make_sample(HEIGHT_W'(2), 8'h11, 1'b0, 1'b1));
   endtask

   task automatic test_span_floor();
      send_sample(make_sample(HEIGHT_W'(0), 8'h20, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_W'(255), 8'h21, 1'b1, 1'b1));
      send_sample(make_sample(HEIGHT_W'(0), 8'h20, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_W'(257), 8'h21, 1'b1, 1'b1));
   endtask

   task automatic test_class_mode();
      // tie between two classes, the one that got there first wins
      send_sample(make_sample(HEIGHT_W'(100), 8'd5, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_W'(200), 8'd9, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_W'(300), 8'd9, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_W'(400), 8'd5, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_W'(500), 8'd9, 1'b0, 1'b0));
      send_sample(make_sample(HEIGHT_W'(600), 8'd200, 1'b0, 1'b1));
      // no class anywhere in the tile
      send_sample(make_sample(HEIGHT_W'(-700), 8'd77, 1'b0, 1'b0));
      send_sample(make_sample(HEIGHT_W'(-800), 8'd78, 1'b0, 1'b1));
      // later class overtakes
      send_sample(make_sample(HEIGHT_W'(10), 8'd3, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_W'(20), 8'd7, 1'b1, 1'b0));
      send_sample(make_sample(HEIGHT_W'(30), 8'd7, 1'b1, 1'b1));
   endtask

   task automatic test_capacity();
      send_tile(MAX_SAMPLES + $urandom_range(1, 8));
   endtask

   task automatic test_random_tiles(input int min_samples, input int min_tiles);
      int first_sample;
      int tiles;
      int length;
      first_sample = samples_sent;
      tiles = 0;
      while (samples_sent - first_sample < min_samples || tiles < min_tiles) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6, 7: length = 1;
            8: length = $urandom_range(2, 4);
            default: length = $urandom_range(5, 8);
         endcase
         send_tile(length);
         tiles++;
      end
   endtask

   initial begin
      clear_tile();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_sample_tiles();
      test_full_height_span();
      test_mean_truncation();
      test_span_floor();
      test_class_mode();

      src_idle_pct = 29;
      sink_stall_pct = 29;
      test_capacity();

      src_idle_pct = 0;
      sink_stall_pct = 0;
      test_random_tiles(100, 64);
      src_idle_pct = 45;
      sink_stall_pct = 0;
      test_random_tiles(100, 64);
      src_idle_pct = 0;
      sink_stall_pct = 45;
      test_random_tiles(100, 64);
      src_idle_pct = 29;
      sink_stall_pct = 29;
      test_random_tiles(100, 64);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d samples in %0d tile summaries, %0d tiles ran past capacity",
         samples_sent, summaries_checked, overflow_tiles);
      $display("with no idling, sender gaps, receiver stalls and both together");
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== height_tile_stats_and_class_mode.f =====
+incdir+hdl
hdl/htsc_pkg.sv
hdl/htsc_div.sv
hdl/height_tile_stats_and_class_mode.sv
dv/tb.sv
